// ----- rtl/qte_pkg.sv -----
`default_nettype none
package qte_pkg;

    // CORDIC step count, 8 to 32
    localparam int CORDIC_ITERATIONS = 16;

    // Operand widths
    localparam int OP_W   = 34;  // 2*(ab +/- cd) and 1 - 2*(aa + bb)
    localparam int COR_W  = 37;  // CORDIC datapath with growth margin
    localparam int SQ_W   = 60;  // square of the pitch sine magnitude
    localparam int RAD_W  = 62;  // square root remainder and partial root
    localparam int ROOT_W = 31;  // root of at most 2^60

    // Square root steps: one result bit per step
    localparam int SQRT_STEPS = 31;

    // Pipeline stage map
    localparam int S_IN       = 0;
    localparam int S_PROD     = 1;
    localparam int S_SUM      = 2;
    localparam int S_SQ       = 3;
    localparam int S_SQRT0    = 4;
    localparam int S_COR0     = S_SQRT0 + SQRT_STEPS;
    localparam int COR_STAGES = CORDIC_ITERATIONS + 1;
    localparam int S_OUT      = S_COR0 + COR_STAGES;
    localparam int N_STG      = S_OUT + 1;

    localparam logic signed [15:0] HALF_PI_16 = 16'sd16384;

    typedef logic signed [OP_W-1:0] op_t;

    // atan(2^-i) as a 32-bit binary angle, 2^32 = 2*pi
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:  val = 32'd536870912;
            5'd1:  val = 32'd316933406;
            5'd2:  val = 32'd167458907;
            5'd3:  val = 32'd85004756;
            5'd4:  val = 32'd42667331;
            5'd5:  val = 32'd21354465;
            5'd6:  val = 32'd10679838;
            5'd7:  val = 32'd5340245;
            5'd8:  val = 32'd2670163;
            5'd9:  val = 32'd1335087;
            5'd10: val = 32'd667544;
            5'd11: val = 32'd333772;
            5'd12: val = 32'd166886;
            5'd13: val = 32'd83443;
            5'd14: val = 32'd41722;
            5'd15: val = 32'd20861;
            5'd16: val = 32'd10430;
            5'd17: val = 32'd5215;
            5'd18: val = 32'd2608;
            5'd19: val = 32'd1304;
            5'd20: val = 32'd652;
            5'd21: val = 32'd326;
            5'd22: val = 32'd163;
            5'd23: val = 32'd81;
            5'd24: val = 32'd41;
            5'd25: val = 32'd20;
            5'd26: val = 32'd10;
            5'd27: val = 32'd5;
            5'd28: val = 32'd3;
            5'd29: val = 32'd1;
            5'd30: val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/quaternion_to_euler.sv -----
`default_nettype none
// Unit quaternion (Q1.15) to ZYX Euler angles as 16-bit binary angles
// (32768 = pi). Fully pipelined: one quaternion per cycle while the output
// is not stalled. The pipeline runs through the 31-stage square root for
// the pitch cosine followed by the CORDIC vectoring stages; roll and yaw
// ride alongside and use their own CORDIC stages. Each stage holds only
// while its successor is full and stalled, so bubbles are squeezed out
// under output back-pressure.
// pitch_clamped marks |2(wy - zx)| >= 1, where pitch is pinned at +/-pi/2.
module quaternion_to_euler
    import qte_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire  signed [15:0] s_quat_w,
    input  wire  signed [15:0] s_quat_x,
    input  wire  signed [15:0] s_quat_y,
    input  wire  signed [15:0] s_quat_z,
    output logic              m_valid,
    input  wire               m_ready,
    output logic signed [15:0] m_roll_angle,
    output logic signed [15:0] m_pitch_angle,
    output logic signed [15:0] m_yaw_angle,
    output logic              m_pitch_clamped
);

    logic [N_STG-1:0] v_reg;
    logic [N_STG:0]   rdy;

    // Stage handshake: a stage loads when empty or when its successor loads
    assign rdy[N_STG] = m_ready;
    for (genvar k = 0; k < N_STG; k++) begin : g_ctl
        assign rdy[k] = !v_reg[k] || rdy[k+1];
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                if (k == 0) begin
                    v_reg[k] <= s_valid;
                end else begin
                    v_reg[k] <= v_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[S_OUT];

    // Capture the request
    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    always_ff @(posedge aclk) begin
        if (rdy[S_IN]) begin
            w_reg <= s_quat_w;
            x_reg <= s_quat_x;
            y_reg <= s_quat_y;
            z_reg <= s_quat_z;
        end
    end

    // Products, exact in Q2.30
    logic signed [31:0] wy_reg, zx_reg, wx_reg, yz_reg, wz_reg, xy_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg;
    always_ff @(posedge aclk) begin
        if (rdy[S_PROD]) begin
            wy_reg <= w_reg * y_reg;
            zx_reg <= z_reg * x_reg;
            wx_reg <= w_reg * x_reg;
            yz_reg <= y_reg * z_reg;
            wz_reg <= w_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
        end
    end

    // Angle operands and pitch sine magnitude
    op_t s_next, ry_next, rx_next, yy_next, yx_next, mag_next;
    op_t s_reg, ry_reg, rx_reg, yy2_reg, yx_reg;
    logic [29:0] mag_reg;
    logic        clamp_reg, neg_reg;
    localparam op_t Q30_ONE = op_t'(1) <<< 30;

    always_comb begin
        s_next   = (op_t'(wy_reg) - op_t'(zx_reg)) <<< 1;
        ry_next  = (op_t'(wx_reg) + op_t'(yz_reg)) <<< 1;
        rx_next  = Q30_ONE - ((op_t'(xx_reg) + op_t'(yy_reg)) <<< 1);
        yy_next  = (op_t'(wz_reg) + op_t'(xy_reg)) <<< 1;
        yx_next  = Q30_ONE - ((op_t'(yy_reg) + op_t'(zz_reg)) <<< 1);
        mag_next = (s_next < 0) ? -s_next : s_next;
    end

    always_ff @(posedge aclk) begin
        if (rdy[S_SUM]) begin
            s_reg     <= s_next;
            ry_reg    <= ry_next;
            rx_reg    <= rx_next;
            yy2_reg   <= yy_next;
            yx_reg    <= yx_next;
            clamp_reg <= (mag_next >= Q30_ONE);
            neg_reg   <= (s_next < 0);
            mag_reg   <= mag_next[29:0];
        end
    end

    // Square of the sine, plus carry of the other operands
    logic [SQ_W-1:0] sq_reg;
    op_t  s3_reg, ry3_reg, rx3_reg, yy3_reg, yx3_reg;
    logic clamp3_reg, neg3_reg;
    always_ff @(posedge aclk) begin
        if (rdy[S_SQ]) begin
            sq_reg     <= mag_reg * mag_reg;
            s3_reg     <= s_reg;
            ry3_reg    <= ry_reg;
            rx3_reg    <= rx_reg;
            yy3_reg    <= yy2_reg;
            yx3_reg    <= yx_reg;
            clamp3_reg <= clamp_reg;
            neg3_reg   <= neg_reg;
        end
    end

    // Cosine of pitch: root of 1 - s^2
    logic [ROOT_W-1:0] root;
    qte_sqrt u_sqrt (
        .aclk  (aclk),
        .en    (rdy[S_SQRT0 +: SQRT_STEPS]),
        .sq_in (sq_reg),
        .root  (root)
    );

    // Delay line beside the square root
    op_t  sd_reg  [0:SQRT_STEPS-1];
    op_t  ryd_reg [0:SQRT_STEPS-1];
    op_t  rxd_reg [0:SQRT_STEPS-1];
    op_t  yyd_reg [0:SQRT_STEPS-1];
    op_t  yxd_reg [0:SQRT_STEPS-1];
    logic cld_reg [0:SQRT_STEPS-1];
    logic ngd_reg [0:SQRT_STEPS-1];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (rdy[S_SQRT0 + k]) begin
                if (k == 0) begin
                    sd_reg[k]  <= s3_reg;
                    ryd_reg[k] <= ry3_reg;
                    rxd_reg[k] <= rx3_reg;
                    yyd_reg[k] <= yy3_reg;
                    yxd_reg[k] <= yx3_reg;
                    cld_reg[k] <= clamp3_reg;
                    ngd_reg[k] <= neg3_reg;
                end else begin
                    sd_reg[k]  <= sd_reg[(k == 0) ? 0 : k-1];
                    ryd_reg[k] <= ryd_reg[(k == 0) ? 0 : k-1];
                    rxd_reg[k] <= rxd_reg[(k == 0) ? 0 : k-1];
                    yyd_reg[k] <= yyd_reg[(k == 0) ? 0 : k-1];
                    yxd_reg[k] <= yxd_reg[(k == 0) ? 0 : k-1];
                    cld_reg[k] <= cld_reg[(k == 0) ? 0 : k-1];
                    ngd_reg[k] <= ngd_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // Three atan2 units side by side
    logic [15:0] roll_ang, pitch_ang, yaw_ang;
    op_t         cos_op;
    assign cos_op = op_t'(root);

    qte_cordic u_roll (
        .aclk  (aclk),
        .en    (rdy[S_COR0 +: COR_STAGES]),
        .y_in  (ryd_reg[SQRT_STEPS-1]),
        .x_in  (rxd_reg[SQRT_STEPS-1]),
        .angle (roll_ang)
    );

    qte_cordic u_pitch (
        .aclk  (aclk),
        .en    (rdy[S_COR0 +: COR_STAGES]),
        .y_in  (sd_reg[SQRT_STEPS-1]),
        .x_in  (cos_op),
        .angle (pitch_ang)
    );

    qte_cordic u_yaw (
        .aclk  (aclk),
        .en    (rdy[S_COR0 +: COR_STAGES]),
        .y_in  (yyd_reg[SQRT_STEPS-1]),
        .x_in  (yxd_reg[SQRT_STEPS-1]),
        .angle (yaw_ang)
    );

    // Carry the clamp and sign flags beside the CORDIC stages
    logic clc_reg [0:COR_STAGES-1];
    logic ngc_reg [0:COR_STAGES-1];
    for (genvar j = 0; j < COR_STAGES; j++) begin : g_cdly
        always_ff @(posedge aclk) begin
            if (rdy[S_COR0 + j]) begin
                if (j == 0) begin
                    clc_reg[j] <= cld_reg[SQRT_STEPS-1];
                    ngc_reg[j] <= ngd_reg[SQRT_STEPS-1];
                end else begin
                    clc_reg[j] <= clc_reg[(j == 0) ? 0 : j-1];
                    ngc_reg[j] <= ngc_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    // Output register: pin pitch at +/-pi/2 when clamped
    always_ff @(posedge aclk) begin
        if (rdy[S_OUT]) begin
            m_roll_angle    <= roll_ang;
            m_yaw_angle     <= yaw_ang;
            m_pitch_clamped <= clc_reg[COR_STAGES-1];
            if (clc_reg[COR_STAGES-1]) begin
                m_pitch_angle <= ngc_reg[COR_STAGES-1] ? -HALF_PI_16 : HALF_PI_16;
            end else begin
                m_pitch_angle <= pitch_ang;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qte_sqrt.sv -----
`default_nettype none
module qte_sqrt
    import qte_pkg::*;
(
    input  wire                     aclk,
    input  wire  [SQRT_STEPS-1:0]   en,
    input  wire  [SQ_W-1:0]         sq_in,
    output logic [ROOT_W-1:0]       root
);

    logic [RAD_W-1:0] v_reg   [0:SQRT_STEPS-1];
    logic [RAD_W-1:0] res_reg [0:SQRT_STEPS-1];

    // Restoring root: one result bit per stage, from bit 60 down
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (60 - 2 * k);
        logic [RAD_W-1:0] v_in, res_in, trial, v_next, res_next;

        if (k == 0) begin : g_first
            assign v_in   = (RAD_W'(1) << 60) - RAD_W'(sq_in);
            assign res_in = '0;
        end else begin : g_rest
            assign v_in   = v_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (v_in >= trial) begin
                v_next   = v_in - trial;
                res_next = (res_in >> 1) + BIT;
            end else begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                v_reg[k]   <= v_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[SQRT_STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/qte_cordic.sv -----
`default_nettype none
module qte_cordic
    import qte_pkg::*;
(
    input  wire                     aclk,
    input  wire  [COR_STAGES-1:0]   en,
    input  wire  signed [OP_W-1:0]  y_in,
    input  wire  signed [OP_W-1:0]  x_in,
    output logic [15:0]             angle
);

    logic signed [COR_W-1:0] x_reg [0:CORDIC_ITERATIONS];
    logic signed [COR_W-1:0] y_reg [0:CORDIC_ITERATIONS];
    logic        [31:0]      z_reg [0:CORDIC_ITERATIONS];
    logic                    zero_reg [0:CORDIC_ITERATIONS];

    logic signed [COR_W-1:0] x_ext, y_ext;
    logic [31:0]             z_round;

    assign x_ext = COR_W'(x_in);
    assign y_ext = COR_W'(y_in);

    // Fold the left half plane onto the right one
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                x_reg[0] <= -x_ext;
                y_reg[0] <= -y_ext;
                z_reg[0] <= 32'h8000_0000;
            end else begin
                x_reg[0] <= x_ext;
                y_reg[0] <= y_ext;
                z_reg[0] <= '0;
            end
        end
    end

    // Vectoring steps: drive y toward zero, one stage each
    for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
        localparam logic [4:0] SH = 5'(i);
        logic signed [COR_W-1:0] xs, ys;
        logic [31:0]             step;

        assign xs   = x_reg[i] >>> SH;
        assign ys   = y_reg[i] >>> SH;
        assign step = atan_entry(SH);

        always_ff @(posedge aclk) begin
            if (en[i+1]) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + step;
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - step;
                end
            end
        end
    end

    // Round the binary angle to 16 bits
    assign z_round = z_reg[CORDIC_ITERATIONS] + 32'h0000_8000;
    assign angle   = zero_reg[CORDIC_ITERATIONS] ? 16'd0 : z_round[31:16];

endmodule
`default_nettype wire

// ----- rtl/qte_checker.sv -----
`default_nettype none
module qte_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_valid,
    input wire               s_ready,
    input wire signed [15:0] s_quat_w,
    input wire signed [15:0] s_quat_x,
    input wire signed [15:0] s_quat_y,
    input wire signed [15:0] s_quat_z,
    input wire               m_valid,
    input wire               m_ready,
    input wire signed [15:0] m_roll_angle,
    input wire signed [15:0] m_pitch_angle,
    input wire signed [15:0] m_yaw_angle,
    input wire               m_pitch_clamped
);

    // Pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Waiting request holds until accepted
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_quat_w) && $stable(s_quat_x)
            && $stable(s_quat_y) && $stable(s_quat_z))
        else $error("waiting request changed");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pitch_angle)
            && $stable(m_roll_angle) && $stable(m_yaw_angle))
        else $error("stalled result changed");

    // Clamped pitch sits at +/-pi/2
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pitch_clamped |->
            m_pitch_angle == 16'sd16384 || m_pitch_angle == -16'sd16384)
        else $error("clamped pitch not at a pole");

    // Pitch never leaves +/-pi/2
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pitch_angle >= -16'sd16384 && m_pitch_angle <= 16'sd16384)
        else $error("pitch out of range");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (.*);
`default_nettype wire
